FILE: rtl/upcd_pkg.sv
package upcd_pkg;

  // Special characters of the serial line.
  localparam logic [7:0] BLANK_CHAR = 8'd95;
  localparam logic [7:0] CR_CHAR    = 8'd13;
  localparam logic [7:0] BKSP_CHAR  = 8'd8;

  // Event codes reported with each result.
  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_OFF   = 3'd1;
  localparam logic [2:0] EV_ON    = 3'd2;
  localparam logic [2:0] EV_QUERY = 3'd3;
  localparam logic [2:0] EV_DUTY  = 3'd4;

  localparam logic [6:0] DUTY_MAX   = 7'd100;
  localparam logic [6:0] DUTY_RESET = 7'd50;

  // Sequencer strobes into the frame walker.
  typedef struct packed {
    logic start;  // clear walker state at the start of a line walk
    logic step;   // consume one stored byte
  } walk_ctl_t;

  // Walker status and the decoded command result.
  typedef struct packed {
    logic       taken;
    logic       err;
    logic [2:0] cmd_event;
    logic [6:0] cmd_duty;
  } walk_stat_t;

endpackage

FILE: rtl/upcd_frame_walk.sv
module upcd_frame_walk (
  input  logic                  clk,
  input  logic                  rst_n,
  input  upcd_pkg::walk_ctl_t   ctl,
  input  logic [7:0]            rx_byte,
  input  logic [6:0]            duty_cur,
  output upcd_pkg::walk_stat_t  stat
);

  localparam int STORE_DEPTH = 8;

  logic [2:0] cnt_r;
  logic [2:0] size_r;
  logic       taken_r;
  logic       err_r;
  logic [7:0] frame_r [0:STORE_DEPTH-1];
  logic [7:0] store_r [0:STORE_DEPTH-1];

  logic       is_t;
  logic       size_ok;
  logic [2:0] last_pos;

  function automatic logic [7:0] upcase(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h61 && b <= 8'h7A) begin
      r = b - 8'd32;
    end
    return r;
  endfunction

  assign is_t     = (rx_byte == 8'h54) || (rx_byte == 8'h74);
  assign size_ok  = (rx_byte >= 8'h30) && (rx_byte <= 8'h35);
  assign last_pos = size_r + 3'd2;

  // One byte per step: the same compare unit hunts for the start letter,
  // checks the size digit and finally checks for the closing CR.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.start) begin
      cnt_r   <= '0;
      taken_r <= 1'b0;
      err_r   <= 1'b0;
      for (int j = 0; j < STORE_DEPTH; j++) begin
        store_r[j] <= upcd_pkg::BLANK_CHAR;
      end
    end else if (ctl.step) begin
      case (cnt_r)
        3'd0: begin
          if (is_t) begin
            cnt_r <= 3'd1;
          end
        end
        3'd1: begin
          if (size_ok) begin
            size_r <= rx_byte[2:0];
            cnt_r  <= 3'd2;
          end else begin
            cnt_r <= '0;
            err_r <= 1'b1;
          end
        end
        default: begin
          if (cnt_r == last_pos) begin
            cnt_r <= '0;
            if (rx_byte == upcd_pkg::CR_CHAR && !taken_r) begin
              taken_r <= 1'b1;
              for (int j = 0; j < STORE_DEPTH; j++) begin
                if (3'(j) < cnt_r) begin
                  store_r[j] <= upcase(frame_r[j]);
                end else if (3'(j) == cnt_r) begin
                  store_r[j] <= upcase(rx_byte);
                end
              end
            end else begin
              err_r <= 1'b1;
            end
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      frame_r[cnt_r] <= rx_byte;
    end
  end

  // Command decode over the upper-cased store.
  logic       is_off, is_on, is_q, is_inc, is_dec, num_ok;
  logic [6:0] tens;
  logic [8:0] sum;
  logic [6:0] two_digit;
  logic [2:0] ev;
  logic [6:0] duty;

  assign is_off = {store_r[0], store_r[1], store_r[2], store_r[3], store_r[4], store_r[5],
                   store_r[6]} == "T5D OFF";
  assign is_on  = {store_r[0], store_r[1], store_r[2], store_r[3], store_r[4], store_r[5]}
                  == "T4D ON";
  assign is_q   = {store_r[0], store_r[1], store_r[2], store_r[3], store_r[4]} == "T3D ?";
  assign is_inc = {store_r[0], store_r[1], store_r[2], store_r[3], store_r[4]} == "T3D +";
  assign is_dec = {store_r[0], store_r[1], store_r[2], store_r[3], store_r[4]} == "T3D -";
  assign num_ok = (store_r[4] >= 8'h30) && (store_r[4] <= 8'h39);

  assign tens = ({3'b000, store_r[4][3:0]} << 3) + ({3'b000, store_r[4][3:0]} << 1);
  assign sum  = {2'b00, tens} + {1'b0, store_r[5]};

  always_comb begin
    if (sum < 9'd48) begin
      two_digit = '0;
    end else if (sum > 9'd148) begin
      two_digit = upcd_pkg::DUTY_MAX;
    end else begin
      two_digit = 7'(sum - 9'd48);
    end
  end

  always_comb begin
    ev   = upcd_pkg::EV_NONE;
    duty = duty_cur;
    if (is_off) begin
      ev = upcd_pkg::EV_OFF;
    end else if (is_on) begin
      ev = upcd_pkg::EV_ON;
    end else if (is_q) begin
      ev = upcd_pkg::EV_QUERY;
    end else if (is_inc) begin
      ev = upcd_pkg::EV_DUTY;
      if (duty_cur < upcd_pkg::DUTY_MAX) begin
        duty = duty_cur + 7'd1;
      end
    end else if (is_dec) begin
      ev = upcd_pkg::EV_DUTY;
      if (duty_cur != 7'd0) begin
        duty = duty_cur - 7'd1;
      end
    end else if (num_ok) begin
      ev = upcd_pkg::EV_DUTY;
      if (store_r[1] == 8'h33) begin
        duty = {3'b000, store_r[4][3:0]};
      end else if (store_r[1] == 8'h35) begin
        duty = upcd_pkg::DUTY_MAX;
      end else begin
        duty = two_digit;
      end
    end
  end

  assign stat.taken     = taken_r;
  assign stat.err       = err_r;
  assign stat.cmd_event = ev;
  assign stat.cmd_duty  = duty;

endmodule

FILE: rtl/uart_pwm_command_decoder.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_stall    in_rx_byte[7:0]
// out_      output     out_valid/out_stall  out_duty_percent[6:0], out_pwm_compare[7:0],
//                                           out_event_res[2:0], out_frame_error
//
// An ordinary byte or a backspace has its result registered at the edge that accepts
// the request.
// A carriage return is accepted in ST_IDLE, then walks min(bytes in the line,
// LINE_DEPTH) entries through the shared frame compare unit in ST_WALK, decodes in
// ST_DECODE and does the PWM compare multiply in ST_FINISH.
// Reset (rst_n low, synchronous) blanks the line buffer, zeroes the write position
// and byte count and sets the duty to 50 percent.
// in_stall is high while a carriage return is in walk, decode or finish and while an
// earlier result waits under out_stall; the result register is held steady until it is taken.
module uart_pwm_command_decoder #(
  parameter int LINE_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_duty_percent,
  output logic [7:0] out_pwm_compare,
  output logic [2:0] out_event_res,
  output logic       out_frame_error
);

  localparam int IDX_W = $clog2(LINE_DEPTH);
  localparam int LEN_W = $clog2(LINE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_DEPTH - 1);
  localparam logic [7:0] DEPTH_B = 8'(LINE_DEPTH);

  // floor(duty * 255 / 100) as duty * 10445 / 4096; exact for duty 0..100.
  localparam logic [20:0] PWM_MUL   = 21'd10445;
  localparam int          PWM_SHIFT = 12;
  localparam logic [7:0]  PWM_RESET = 8'(50 * 255 / 100);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_DECODE = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]       state_r;
  logic [7:0]       line_buf_r [0:LINE_DEPTH-1];
  logic [IDX_W-1:0] wp_r;
  logic [7:0]       br_r;
  logic [IDX_W-1:0] idx_r;
  logic [LEN_W-1:0] len_r;
  logic [6:0]       duty_r;
  logic [7:0]       pwm_r;
  logic [2:0]       event_r;

  logic             out_valid_r;
  logic [6:0]       out_duty_r;
  logic [7:0]       out_pwm_r;
  logic [2:0]       out_event_r;
  logic             out_err_r;

  logic             in_acc;
  logic             out_take;
  logic             is_bksp;
  logic             is_cr;
  logic [IDX_W-1:0] wp_inc;
  logic [IDX_W-1:0] wp_dec;
  logic [7:0]       br_inc;
  logic [LEN_W-1:0] line_len;
  logic             walk_last;
  logic [20:0]      pwm_prod;

  upcd_pkg::walk_ctl_t  wctl;
  upcd_pkg::walk_stat_t wstat;

  // Requests are taken only by an idle sequencer whose result register is free or
  // being emptied in this cycle.
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && (!out_valid_r || !out_stall));
  assign in_acc   = in_valid && !in_stall;

  assign is_bksp = (in_rx_byte == upcd_pkg::BKSP_CHAR);
  assign is_cr   = (in_rx_byte == upcd_pkg::CR_CHAR);
  assign wp_inc  = (wp_r == LAST_IDX) ? '0 : wp_r + IDX_W'(1);
  assign wp_dec  = (wp_r != '0) ? wp_r - IDX_W'(1) : '0;
  assign br_inc  = (br_r == 8'hFF) ? br_r : br_r + 8'd1;

  // The walk covers at most LINE_DEPTH entries, starting at entry zero.
  assign line_len  = (br_inc > DEPTH_B) ? LEN_W'(LINE_DEPTH) : br_inc[LEN_W-1:0];
  assign walk_last = (LEN_W'(idx_r) + LEN_W'(1)) == len_r;

  assign pwm_prod = 21'(duty_r) * PWM_MUL;

  assign wctl.start = in_acc && is_cr && !is_bksp;
  assign wctl.step  = (state_r == ST_WALK);

  upcd_frame_walk u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (wctl),
    .rx_byte  (line_buf_r[idx_r]),
    .duty_cur (duty_r),
    .stat     (wstat)
  );

  // Line buffer. An accepted command blanks the whole line.
  always_ff @(posedge clk) begin
    if (!rst_n || (state_r == ST_DECODE && wstat.taken)) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        line_buf_r[i] <= upcd_pkg::BLANK_CHAR;
      end
    end else if (in_acc) begin
      if (is_bksp) begin
        line_buf_r[wp_dec] <= upcd_pkg::BLANK_CHAR;
      end else begin
        line_buf_r[wp_r] <= in_rx_byte;
      end
    end
  end

  // Sequencer and line bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      br_r    <= '0;
      idx_r   <= '0;
      len_r   <= '0;
      duty_r  <= upcd_pkg::DUTY_RESET;
      pwm_r   <= PWM_RESET;
      event_r <= upcd_pkg::EV_NONE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (is_bksp) begin
              wp_r <= wp_dec;
              if (br_r != 8'd0) begin
                br_r <= br_r - 8'd1;
              end
            end else if (is_cr) begin
              wp_r    <= '0;
              br_r    <= '0;
              idx_r   <= '0;
              len_r   <= line_len;
              state_r <= ST_WALK;
            end else begin
              wp_r <= wp_inc;
              br_r <= br_inc;
            end
          end
        end
        ST_WALK: begin
          idx_r <= idx_r + IDX_W'(1);
          if (walk_last) begin
            state_r <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          if (wstat.taken) begin
            duty_r  <= wstat.cmd_duty;
            event_r <= wstat.cmd_event;
          end else begin
            event_r <= upcd_pkg::EV_NONE;
          end
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          pwm_r   <= pwm_prod[PWM_SHIFT+7:PWM_SHIFT];
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Result register. A carriage return posts its result from the finish cycle; the
  // register is known to be empty by then because the request was taken only when it
  // was free or draining.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((in_acc && !is_cr) || state_r == ST_FINISH) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH) begin
      out_duty_r  <= duty_r;
      out_pwm_r   <= pwm_prod[PWM_SHIFT+7:PWM_SHIFT];
      out_event_r <= event_r;
      out_err_r   <= wstat.err;
    end else if (in_acc && !is_cr) begin
      out_duty_r  <= duty_r;
      out_pwm_r   <= pwm_r;
      out_event_r <= upcd_pkg::EV_NONE;
      out_err_r   <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_duty_percent = out_duty_r;
  assign out_pwm_compare  = out_pwm_r;
  assign out_event_res    = out_event_r;
  assign out_frame_error  = out_err_r;

  // The result register must be free when a line walk posts its result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> !out_valid_r)
    else $error("line result would overwrite a pending result");

  // The duty never leaves its 0..100 range.
  assert property (@(posedge clk) disable iff (!rst_n)
    duty_r <= upcd_pkg::DUTY_MAX)
    else $error("duty out of range");

  // The walk index stays inside the walked length.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (LEN_W'(idx_r) < len_r))
    else $error("walk index beyond line length");

  // An ordinary byte or a backspace yields a plain result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_cr) |=> (out_valid_r && out_event_r == upcd_pkg::EV_NONE && !out_err_r))
    else $error("plain byte did not post a plain result");

  // The stored compare value tracks the duty while idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (pwm_r == pwm_prod[PWM_SHIFT+7:PWM_SHIFT]))
    else $error("PWM compare value out of step with duty");

endmodule

FILE: bench/duty_report_checker.sv
module duty_report_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [6:0] out_duty_percent,
  input  logic [7:0] out_pwm_compare,
  input  logic [2:0] out_event_res,
  input  logic       out_frame_error,
  output int         mismatch_count,
  output int         reports_pending
);

  localparam int LINE_DEPTH  = 8;
  localparam int STORE_DEPTH = 8;

  typedef struct packed {
    logic [6:0] duty;
    logic [7:0] compare;
    logic [2:0] ev;
    logic       ferr;
  } duty_report_t;

  logic [7:0]   line_buf [LINE_DEPTH];
  logic [7:0]   cmd_store [STORE_DEPTH];
  logic [2:0]   wr_pos;
  logic [7:0]   rx_count;
  logic [6:0]   duty;
  duty_report_t due_reports [$];
  duty_report_t got_report;
  duty_report_t want_report;
  int           errors = 0;

  task automatic clear_line();
    for (int i = 0; i < LINE_DEPTH; i++) begin
      line_buf[i]  = upcd_pkg::BLANK_CHAR;
      cmd_store[i] = upcd_pkg::BLANK_CHAR;
    end
    wr_pos   = '0;
    rx_count = '0;
  endtask

  // Walks the stored line from entry 0 looking for T, size digit, size+1 bytes ending in CR.
  task automatic scan_line(input int unsigned n, output bit taken, output bit ferr);
    logic [7:0]  frame [STORE_DEPTH];
    logic [7:0]  b;
    int unsigned cnt;
    int unsigned size;
    taken = 1'b0;
    ferr  = 1'b0;
    cnt   = 0;
    size  = 0;
    if (n > LINE_DEPTH) n = LINE_DEPTH;
    for (int unsigned k = 0; k < n; k++) begin
      b = line_buf[k];
      if (cnt == 0) begin
        if (b == "T" || b == "t") begin
          frame[0] = b;
          cnt = 1;
        end
      end else if (cnt == 1) begin
        if (b < "0" || b > "5") begin
          cnt  = 0;
          ferr = 1'b1;
        end else begin
          frame[1] = b;
          size = int'(b) - 48;
          cnt = 2;
        end
      end else begin
        frame[cnt] = b;
        cnt++;
        if (cnt >= size + 3) begin
          cnt = 0;
          if (frame[size + 2] == upcd_pkg::CR_CHAR && !taken) begin
            for (int unsigned j = 0; j <= size + 2; j++) cmd_store[j] = frame[j];
            taken = 1'b1;
          end else begin
            ferr = 1'b1;
          end
        end
      end
    end
    for (int j = 0; j < STORE_DEPTH; j++) begin
      if (cmd_store[j] >= "a" && cmd_store[j] <= "z") cmd_store[j] = cmd_store[j] - 8'd32;
    end
  endtask

  task automatic run_command(output logic [2:0] ev);
    logic [55:0] head;
    int          v;
    head = {cmd_store[0], cmd_store[1], cmd_store[2], cmd_store[3],
            cmd_store[4], cmd_store[5], cmd_store[6]};
    if (head == "T5D OFF") begin
      ev = upcd_pkg::EV_OFF;
    end else if (head[55:8] == "T4D ON") begin
      ev = upcd_pkg::EV_ON;
    end else if (head[55:16] == "T3D ?") begin
      ev = upcd_pkg::EV_QUERY;
    end else if (head[55:16] == "T3D +") begin
      if (duty < upcd_pkg::DUTY_MAX) duty = duty + 7'd1;
      ev = upcd_pkg::EV_DUTY;
    end else if (head[55:16] == "T3D -") begin
      if (duty > 7'd0) duty = duty - 7'd1;
      ev = upcd_pkg::EV_DUTY;
    end else if (cmd_store[4] >= "0" && cmd_store[4] <= "9") begin
      if (cmd_store[1] == "3") v = int'(cmd_store[4]) - 48;
      else if (cmd_store[1] == "5") v = 100;
      else v = (int'(cmd_store[4]) - 48) * 10 + (int'(cmd_store[5]) - 48);
      if (v < 0) v = 0;
      if (v > 100) v = 100;
      duty = 7'(v);
      ev = upcd_pkg::EV_DUTY;
    end else begin
      ev = upcd_pkg::EV_NONE;
    end
  endtask

  task automatic decode_rx_byte(input logic [7:0] b, output duty_report_t r);
    bit          taken;
    bit          ferr;
    logic [2:0]  ev;
    int unsigned n;
    ev   = upcd_pkg::EV_NONE;
    ferr = 1'b0;
    if (b != upcd_pkg::BKSP_CHAR) begin
      line_buf[wr_pos] = b;
      wr_pos = wr_pos + 3'd1;
      if (rx_count < 8'd255) rx_count = rx_count + 8'd1;
      if (b == upcd_pkg::CR_CHAR) begin
        n = rx_count;
        rx_count = '0;
        wr_pos = '0;
        scan_line(n, taken, ferr);
        if (taken) begin
          run_command(ev);
          clear_line();
        end
      end
    end else begin
      if (rx_count > 8'd0) rx_count = rx_count - 8'd1;
      if (wr_pos > 3'd0) wr_pos = wr_pos - 3'd1;
      line_buf[wr_pos] = upcd_pkg::BLANK_CHAR;
    end
    r.duty    = duty;
    r.compare = 8'((int'(duty) * 255) / 100);
    r.ev      = ev;
    r.ferr    = ferr;
  endtask

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_line();
      duty = upcd_pkg::DUTY_RESET;
      due_reports.delete();
    end else begin
      // A result can never leave at the edge that accepts its own request, so retire first.
      if (out_valid && !out_stall) begin
        got_report = '{out_duty_percent, out_pwm_compare, out_event_res, out_frame_error};
        if (due_reports.size() == 0) begin
          $display("%0t: unexpected result duty %0d compare %0d event %0d error %0d",
                   $time, out_duty_percent, out_pwm_compare, out_event_res, out_frame_error);
          errors++;
        end else begin
          want_report = due_reports.pop_front();
          check_field("duty_percent", 8'(want_report.duty), 8'(got_report.duty));
          check_field("pwm_compare", want_report.compare, got_report.compare);
          check_field("event_res", 8'(want_report.ev), 8'(got_report.ev));
          check_field("frame_error", 8'(want_report.ferr), 8'(got_report.ferr));
        end
      end
      if (in_valid && !in_stall) begin
        decode_rx_byte(in_rx_byte, want_report);
        due_reports.push_back(want_report);
      end
    end
    reports_pending <= due_reports.size();
    mismatch_count  <= errors;
  end

endmodule

FILE: bench/tb_top.sv
module tb_top;

  // The slowest correct run stays well inside the limit: each request costs its block
  // processing plus a sender gap and a receiver stall, and there is one long receiver
  // hold. The limit leaves a wide margin over that.
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_BYTES = 750;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 20;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_stall  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [6:0] out_duty_percent;
  logic [7:0] out_pwm_compare;
  logic [2:0] out_event_res;
  logic       out_frame_error;

  int         mismatch_count;
  int         reports_pending;
  int         cycle_count = 0;
  int         random_bytes = 0;
  bit         random_phase = 1'b0;
  bit         gapless_line = 1'b0;
  logic [7:0] line_q [$];

  initial begin
    forever #5 clk = ~clk;
  end

  uart_pwm_command_decoder #(
    .LINE_DEPTH(8)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_duty_percent(out_duty_percent),
    .out_pwm_compare (out_pwm_compare),
    .out_event_res   (out_event_res),
    .out_frame_error (out_frame_error)
  );

  // The checker watches both channels, keeps its own copy of the decoder state, and
  // compares every result against the oldest outstanding prediction.
  duty_report_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_duty_percent(out_duty_percent),
    .out_pwm_compare (out_pwm_compare),
    .out_event_res   (out_event_res),
    .out_frame_error (out_frame_error),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending)
  );

  // Watchdog: a hung handshake or a result that never arrives ends the run here.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Gaps between requests are mostly absent or short, with the odd long pause so that
  // idle cycles land on every phase of a line walk.
  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (gapless_line || r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Content byte for random frames: mostly characters that matter to the frame parser,
  // sometimes any byte except backspace and carriage return, which have line effects.
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1: c = $urandom_range(0, 1) ? "T" : "t";
      2, 3: c = 8'($urandom_range(48, 57));
      4: c = " ";
      5: c = 8'($urandom_range(65, 90));
      6: c = 8'($urandom_range(97, 122));
      7: c = $urandom_range(0, 1) ? "+" : ($urandom_range(0, 1) ? "-" : "?");
      default: begin
        c = 8'($urandom_range(0, 255));
        if (c == upcd_pkg::BKSP_CHAR || c == upcd_pkg::CR_CHAR) c = upcd_pkg::BLANK_CHAR;
      end
    endcase
    return c;
  endfunction

  // Letters of a command go out in random case, since the decoder upper-cases a..z.
  task automatic add_text(input string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) c = c + 8'd32;
      line_q.push_back(c);
    end
  endtask

  // One request: valid goes high with the byte and stays there, payload unchanged, until
  // the decoder takes it. The optional gap only drops valid after acceptance.
  task automatic send_rx_byte(input logic [7:0] b, input int unsigned gap);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_rx_byte(line_q[i], sender_gap());
    if (random_phase) random_bytes += line_q.size();
    line_q.delete();
  endtask

  // A well-formed command line: OFF, ON, query, increment, decrement or one of the three
  // numeric forms, sometimes with a leading junk byte or a typo fixed by backspace.
  task automatic build_command_line();
    logic [7:0]  junk;
    int unsigned pos;
    case ($urandom_range(0, 7))
      0: add_text("T5D OFF");
      1: add_text("T4D ON");
      2: add_text("T3D ?");
      3: add_text("T3D +");
      4: add_text("T3D -");
      5: begin
        add_text("T3D ");
        line_q.push_back(8'($urandom_range(48, 57)));
      end
      6: begin
        // The second digit is sometimes any byte, which drives the 0..100 clamp.
        add_text("T4D ");
        line_q.push_back(8'($urandom_range(48, 57)));
        line_q.push_back($urandom_range(0, 3) ? 8'($urandom_range(48, 57)) : pick_char());
      end
      default: begin
        add_text("T5D ");
        line_q.push_back(8'($urandom_range(48, 57)));
        line_q.push_back(pick_char());
        line_q.push_back(pick_char());
      end
    endcase
    line_q.push_back(upcd_pkg::CR_CHAR);
    if (line_q.size() < 8 && $urandom_range(0, 3) == 0) begin
      junk = pick_char();
      if (junk == "T" || junk == "t") junk = " ";
      line_q.push_front(junk);
    end
    if ($urandom_range(0, 4) == 0) begin
      pos = $urandom_range(0, line_q.size() - 1);
      line_q.insert(pos, pick_char());
      line_q.insert(pos + 1, upcd_pkg::BKSP_CHAR);
    end
  endtask

  task automatic build_random_line();
    int unsigned r;
    int unsigned size;
    logic [7:0]  b;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      build_command_line();
    end else if (r < 65) begin
      // Generic frame of any size; now and then the byte where CR belongs is wrong.
      line_q.push_back($urandom_range(0, 1) ? "T" : "t");
      size = $urandom_range(0, 5);
      line_q.push_back(8'(48 + size));
      repeat (size) line_q.push_back(pick_char());
      if ($urandom_range(0, 6) == 0) line_q.push_back(pick_char());
      line_q.push_back(upcd_pkg::CR_CHAR);
    end else if (r < 75) begin
      // Size digit outside 0..5.
      line_q.push_back($urandom_range(0, 1) ? "T" : "t");
      b = pick_char();
      if (b >= "0" && b <= "5") b = "9";
      line_q.push_back(b);
      repeat ($urandom_range(0, 4)) line_q.push_back(pick_char());
      line_q.push_back(upcd_pkg::CR_CHAR);
    end else if (r < 85) begin
      // Lines longer than the buffer wrap; the walk then also sees the older entries,
      // which may hold frames of their own.
      if ($urandom_range(0, 1)) begin
        repeat (8) line_q.push_back(pick_char());
        line_q.push_back("T");
        size = $urandom_range(0, 2);
        line_q.push_back(8'(48 + size));
        repeat (size) line_q.push_back(pick_char());
      end else begin
        repeat ($urandom_range(8, 14)) line_q.push_back(pick_char());
      end
      line_q.push_back(upcd_pkg::CR_CHAR);
    end else begin
      // Raw noise, backspaces included; a stray CR ends the line early.
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 6) == 0) line_q.push_back(upcd_pkg::BKSP_CHAR);
        else line_q.push_back(8'($urandom_range(0, 255)));
      end
      line_q.push_back(upcd_pkg::CR_CHAR);
    end
  endtask

  // Receiver: short stall bursts, stretches without any stall, and once, early in the
  // random part, a long hold so the result register backs up and in_stall rises.
  initial begin : result_side
    int unsigned r;
    int          hold_count;
    bit          hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (random_phase && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(50, 200)) @(posedge clk);
        end else begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
          out_stall <= 1'b1;
          if (r < 92) repeat ($urandom_range(1, 3)) @(posedge clk);
          else repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  initial begin : request_side
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines. A backspace on an empty line must not move below position zero.
    // The two junk bytes 0xFF and 0x00 sit in front of a frame and must be skipped.
    line_q.push_back(upcd_pkg::BKSP_CHAR);
    line_q.push_back(8'hFF);
    add_text("T3D +");
    line_q.push_back(upcd_pkg::CR_CHAR);
    line_q.push_back(8'h00);
    add_text("t3d -");
    line_q.push_back(upcd_pkg::CR_CHAR);
    add_text("T5D OFF");
    line_q.push_back(upcd_pkg::CR_CHAR);
    send_line();

    // Random lines; about one line in four, chosen at random, goes out back to back.
    random_phase = 1'b1;
    while (random_bytes < RANDOM_BYTES) begin
      gapless_line = ($urandom_range(0, 3) == 0);
      build_random_line();
      send_line();
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted result, then let the block settle a little more.
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/upcd_pkg.sv
rtl/upcd_frame_walk.sv
rtl/uart_pwm_command_decoder.sv
bench/duty_report_checker.sv
bench/tb_top.sv
